[rtl/b64d_pkg.sv]
`timescale 1ns / 1ps
package b64d_pkg;

  localparam int unsigned SymW    = 8;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned StatW   = 2;
  localparam int unsigned MaxRes  = 3;

  localparam logic [StatW-1:0] STAT_OK       = 2'd0;
  localparam logic [StatW-1:0] STAT_BAD_CHAR = 2'd1;
  localparam logic [StatW-1:0] STAT_BAD_LEN  = 2'd2;

  localparam logic [SymW-1:0] CH_PLUS  = 8'h2B;
  localparam logic [SymW-1:0] CH_SLASH = 8'h2F;
  localparam logic [SymW-1:0] CH_PAD   = 8'h3D;

  typedef struct packed {
    logic       is_pad;
    logic       is_bad;
    logic [5:0] sextet;
  } sym_class_t;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             last_of_run;
    logic [StatW-1:0] status;
  } result_t;

  function automatic sym_class_t classify(input logic [SymW-1:0] c);
    sym_class_t r;
    r.is_pad = 1'b0;
    r.is_bad = 1'b0;
    r.sextet = 6'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r.sextet = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r.sextet = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r.sextet = 6'(c - 8'h30 + 8'd52);
    end else if (c == CH_PLUS) begin
      r.sextet = 6'd62;
    end else if (c == CH_SLASH) begin
      r.sextet = 6'd63;
    end else if (c == CH_PAD) begin
      r.is_pad = 1'b1;
    end else begin
      r.is_bad = 1'b1;
    end
    return r;
  endfunction

endpackage

[rtl/base64_stream_decoder.sv]
`timescale 1ns / 1ps
// Base64 stream decoder. While in_tready is high, one character is taken per
// cycle into an input register; the next cycle decodes it, updates the group
// state and writes zero to three result transactions into a 16-entry output
// queue, whose head drives the result channel. in_tready drops only when that
// queue could not take the results of the character in flight plus one more,
// so a stream sustains one character per clock while the consumer takes one
// byte per clock. Results are registered in the output queue before they leave.
// Status 1 marks a bad character or misplaced '=', status 2 a text length that
// is not a multiple of four; after an error, input is dropped up to the final
// character and bytes already sent for that text should be discarded.
module base64_stream_decoder
  import b64d_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [SymW-1:0]  in_tdata,   // [7:0] symbol
  input  logic             in_tlast,   // final_char
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [ByteW-1:0] out_tdata,  // [7:0] data_byte
  output logic             out_tlast,  // last_of_run
  output logic [StatW-1:0] out_tuser   // [1:0] status
);

  localparam int unsigned QDepth = 16;
  localparam int unsigned PtrW   = $clog2(QDepth);
  localparam int unsigned CntW   = $clog2(QDepth + 2 * MaxRes + 1);

  logic            v_r;
  logic [SymW-1:0] sym_r;
  logic            fin_r;

  logic [23:0] acc_r, acc_nxt;
  logic [1:0]  pos_r, pos_nxt;
  logic [2:0]  pad_r, pad_nxt;
  logic        done_r, done_nxt;
  logic        skip_r, skip_nxt;

  result_t         q_mem [QDepth];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] cnt_r, cnt_nxt, fill;

  result_t    ent [MaxRes];
  logic [1:0] n_push;
  sym_class_t cls;
  logic       bad;
  logic [23:0] acc_new;
  logic [2:0]  pad_new;
  logic        in_acc, out_acc;

  assign fill      = cnt_r + (v_r ? CntW'(MaxRes) : CntW'(0));
  assign in_tready = (fill <= CntW'(QDepth - MaxRes));
  assign in_acc    = in_tvalid & in_tready;

  assign out_tvalid = (cnt_r != '0);
  assign out_tdata  = q_mem[rd_ptr_r].data_byte;
  assign out_tlast  = q_mem[rd_ptr_r].last_of_run;
  assign out_tuser  = q_mem[rd_ptr_r].status;
  assign out_acc    = out_tvalid & out_tready;

  assign cls     = classify(sym_r);
  assign bad     = cls.is_bad | done_r | ((pad_r != 3'd0) & ~cls.is_pad);
  assign acc_new = {acc_r[17:0], cls.sextet};
  assign pad_new = pad_r + {2'b00, cls.is_pad};

  always_comb begin
    acc_nxt  = acc_r;
    pos_nxt  = pos_r;
    pad_nxt  = pad_r;
    done_nxt = done_r;
    skip_nxt = skip_r;
    n_push   = 2'd0;
    for (int k = 0; k < MaxRes; k++) begin
      ent[k].data_byte   = acc_new[23-8*k -: 8];
      ent[k].last_of_run = 1'b0;
      ent[k].status      = STAT_OK;
    end
    if (v_r) begin
      if (skip_r) begin
        if (fin_r) begin
          acc_nxt  = '0;
          pos_nxt  = '0;
          pad_nxt  = '0;
          done_nxt = 1'b0;
          skip_nxt = 1'b0;
        end
      end else if ((fin_r && pos_r != 2'd3) || bad) begin
        n_push             = 2'd1;
        ent[0].data_byte   = '0;
        ent[0].last_of_run = 1'b1;
        ent[0].status      = (fin_r && pos_r != 2'd3) ? STAT_BAD_LEN : STAT_BAD_CHAR;
        acc_nxt  = '0;
        pos_nxt  = '0;
        pad_nxt  = '0;
        if (fin_r) begin
          done_nxt = 1'b0;
          skip_nxt = 1'b0;
        end else begin
          skip_nxt = 1'b1;
        end
      end else if (pos_r != 2'd3) begin
        acc_nxt = acc_new;
        pad_nxt = pad_new;
        pos_nxt = pos_r + 2'd1;
      end else begin
        case (pad_new)
          3'd0:    n_push = 2'd3;
          3'd1:    n_push = 2'd2;
          3'd2:    n_push = 2'd1;
          3'd3:    n_push = 2'd1;
          default: n_push = 2'd0;
        endcase
        for (int k = 0; k < MaxRes; k++) begin
          ent[k].last_of_run = (2'(k) == n_push - 2'd1);
        end
        acc_nxt  = '0;
        pos_nxt  = '0;
        pad_nxt  = '0;
        done_nxt = fin_r ? 1'b0 : (done_r | (pad_new != 3'd0));
      end
    end
  end

  assign cnt_nxt = cnt_r + CntW'(n_push) - (out_acc ? CntW'(1) : CntW'(0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r      <= 1'b0;
      acc_r    <= '0;
      pos_r    <= '0;
      pad_r    <= '0;
      done_r   <= 1'b0;
      skip_r   <= 1'b0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      v_r      <= in_acc;
      acc_r    <= acc_nxt;
      pos_r    <= pos_nxt;
      pad_r    <= pad_nxt;
      done_r   <= done_nxt;
      skip_r   <= skip_nxt;
      wr_ptr_r <= wr_ptr_r + PtrW'(n_push);
      if (out_acc) begin
        rd_ptr_r <= rd_ptr_r + PtrW'(1);
      end
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      sym_r <= in_tdata;
      fin_r <= in_tlast;
    end
    for (int k = 0; k < MaxRes; k++) begin
      if (2'(k) < n_push) begin
        q_mem[wr_ptr_r + PtrW'(k)] <= ent[k];
      end
    end
  end

endmodule

[test/b64d_checker.sv]
`timescale 1ns / 1ps
module b64d_checker
  import b64d_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_tready,
  input  logic [SymW-1:0]  in_tdata,   // [7:0] symbol
  input  logic             in_tlast,   // final_char
  input  logic             out_tvalid,
  input  logic             out_tready,
  input  logic [ByteW-1:0] out_tdata,  // [7:0] data_byte
  input  logic             out_tlast,  // last_of_run
  input  logic [StatW-1:0] out_tuser,  // [1:0] status
  output int               fail_count,
  output int               pending
);

  typedef enum logic [1:0] {SYM_DATA, SYM_PAD, SYM_BAD} sym_kind_t;

  logic [23:0] acc;
  logic [1:0]  grp_pos;
  logic [2:0]  pad_cnt;
  logic        pad_done;
  logic        skipping;
  result_t     byte_q[$];
  int          errs   = 0;
  int          queued = 0;

  assign fail_count = errs;
  assign pending    = queued;

  function automatic sym_kind_t kind_of(input logic [SymW-1:0] c);
    if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || (c >= "0" && c <= "9") ||
        c == CH_PLUS || c == CH_SLASH) begin
      return SYM_DATA;
    end
    if (c == CH_PAD) begin
      return SYM_PAD;
    end
    return SYM_BAD;
  endfunction

  function automatic logic [5:0] sextet_of(input logic [SymW-1:0] c);
    if (c >= "A" && c <= "Z") begin
      return 6'(c - "A");
    end
    if (c >= "a" && c <= "z") begin
      return 6'(c - "a" + 8'd26);
    end
    if (c >= "0" && c <= "9") begin
      return 6'(c - "0" + 8'd52);
    end
    if (c == CH_PLUS) begin
      return 6'd62;
    end
    return 6'd63;
  endfunction

  task automatic report(input string msg);
    errs++;
    if (errs <= 40) begin
      $display("%0t: %s", $time, msg);
    end
  endtask

  task automatic reset_group();
    acc     = '0;
    grp_pos = '0;
    pad_cnt = '0;
  endtask

  task automatic reset_text();
    reset_group();
    pad_done = 1'b0;
    skipping = 1'b0;
  endtask

  task automatic push_result(input logic [ByteW-1:0] b, input logic l,
                             input logic [StatW-1:0] s);
    result_t r;
    r.data_byte   = b;
    r.last_of_run = l;
    r.status      = s;
    byte_q.push_back(r);
  endtask

  task automatic decode_step(input logic [SymW-1:0] sym, input logic fin);
    sym_kind_t k;
    int        n;
    k = kind_of(sym);
    if (skipping) begin
      if (fin) reset_text();
      return;
    end
    if (fin && grp_pos != 2'd3) begin
      reset_text();
      push_result('0, 1'b1, STAT_BAD_LEN);
      return;
    end
    if (k == SYM_BAD || pad_done || (pad_cnt != 0 && k != SYM_PAD)) begin
      if (fin) begin
        reset_text();
      end else begin
        reset_group();
        skipping = 1'b1;
      end
      push_result('0, 1'b1, STAT_BAD_CHAR);
      return;
    end
    acc = {acc[17:0], (k == SYM_PAD) ? 6'd0 : sextet_of(sym)};
    if (k == SYM_PAD) pad_cnt = pad_cnt + 3'd1;
    if (grp_pos != 2'd3) begin
      grp_pos = grp_pos + 2'd1;
      return;
    end
    case (pad_cnt)
      3'd0:       n = 3;
      3'd1:       n = 2;
      3'd2, 3'd3: n = 1;
      default:    n = 0;
    endcase
    for (int i = 0; i < n; i++) begin
      push_result(acc[23 - 8 * i -: 8], i == n - 1, STAT_OK);
    end
    if (pad_cnt != 0) pad_done = 1'b1;
    reset_group();
    if (fin) reset_text();
  endtask

  always @(posedge clk) begin : monitor
    result_t got;
    result_t want;
    if (!rst_n) begin
      reset_text();
      byte_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.data_byte   = out_tdata;
        got.last_of_run = out_tlast;
        got.status      = out_tuser;
        if (byte_q.size() == 0) begin
          report($sformatf("unexpected result: byte %02h last %0d status %0d",
                           got.data_byte, got.last_of_run, got.status));
        end else begin
          want = byte_q.pop_front();
          if (got.data_byte !== want.data_byte)
            report($sformatf("data_byte: got %02h, expected %02h",
                             got.data_byte, want.data_byte));
          if (got.last_of_run !== want.last_of_run)
            report($sformatf("last_of_run: got %0d, expected %0d",
                             got.last_of_run, want.last_of_run));
          if (got.status !== want.status)
            report($sformatf("status: got %0d, expected %0d", got.status, want.status));
        end
      end
      if (in_tvalid && in_tready) decode_step(in_tdata, in_tlast);
    end
    queued <= byte_q.size();
  end

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
module tb_top
  import b64d_pkg::*;
;

  localparam int IdleLimit  = 2000;
  localparam int HoldCycles = 300;
  localparam int PhaseItems = 64;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [SymW-1:0]  in_tdata   = '0;
  logic             in_tlast   = 1'b0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [ByteW-1:0] out_tdata;
  logic             out_tlast;
  logic [StatW-1:0] out_tuser;

  int               fail_count;
  int               pending;
  int               in_idle_pct   = 0;
  int               out_stall_pct = 0;
  int               sent_count    = 0;
  int               idle_cycles   = 0;
  int               hold_left     = 0;
  logic             hold_req      = 1'b0;
  logic [SymW-1:0]  txt[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  base64_stream_decoder uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  b64d_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // hold off the consumer for a long stretch on request, else stall at random
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_req) begin
      hold_req   <= 1'b0;
      hold_left  <= HoldCycles;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("tb_top failed");
        $finish;
      end
    end
  end

  function automatic logic [SymW-1:0] rand_alpha();
    int idx;
    idx = $urandom_range(63);
    if (idx < 26) return 8'("A" + idx);
    if (idx < 52) return 8'("a" + idx - 26);
    if (idx < 62) return 8'("0" + idx - 52);
    if (idx == 62) return CH_PLUS;
    return CH_SLASH;
  endfunction

  function automatic logic [SymW-1:0] rand_noise();
    int r;
    r = $urandom_range(9);
    if (r < 6) return rand_alpha();
    if (r < 8) return CH_PAD;
    return 8'($urandom_range(255));
  endfunction

  task automatic send_char(input logic [SymW-1:0] s, input logic fin);
    if (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    in_tlast  <= fin;
    do @(posedge clk); while (!in_tready);
    sent_count++;
  endtask

  task automatic send_text();
    for (int i = 0; i < txt.size(); i++) begin
      send_char(txt[i], i == txt.size() - 1);
    end
    txt.delete();
  endtask

  task automatic load(input string s);
    for (int i = 0; i < s.len(); i++) begin
      txt.push_back(s.getc(i));
    end
  endtask

  task automatic make_text();
    int kind;
    int r;
    int np;
    txt.delete();
    kind = $urandom_range(99);
    if (kind < 80) begin
      repeat (4 * $urandom_range(1, 3)) txt.push_back(rand_alpha());
      r  = $urandom_range(9);
      np = (r < 4) ? 0 : (r < 6) ? 1 : (r < 8) ? 2 : (r == 8) ? 3 : 4;
      for (int i = 0; i < np; i++) begin
        txt[txt.size() - 1 - i] = CH_PAD;
      end
      if (kind >= 65) begin
        if ($urandom_range(1) != 0) begin
          repeat ($urandom_range(1, 4)) txt.push_back(rand_noise());
        end else begin
          repeat ($urandom_range(1, 3)) void'(txt.pop_back());
        end
      end else if (kind >= 55) begin
        txt[$urandom_range(txt.size() - 1)] = rand_noise();
      end
    end else begin
      repeat ($urandom_range(1, 10)) txt.push_back(rand_noise());
    end
  endtask

  initial begin : stimulus
    int idle_tab[4];
    int stall_tab[4];
    int phase_start;
    idle_tab  = '{0, 66, 0, 37};
    stall_tab = '{0, 0, 66, 37};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    load("AZaz09+/");
    send_text();
    load("Q/==");
    send_text();
    load("====QUJD");
    send_text();
    txt.push_back(8'hFF);
    send_text();
    load("A=B");
    txt.push_back(8'h00);
    send_text();
    load("//");
    txt.push_back(8'hFF);
    txt.push_back(8'h80);
    send_text();

    for (int ph = 0; ph < 4; ph++) begin
      in_idle_pct   = idle_tab[ph];
      out_stall_pct = stall_tab[ph];
      if (ph == 0) hold_req <= 1'b1;
      phase_start = sent_count;
      while (sent_count - phase_start < PhaseItems) begin
        make_text();
        send_text();
      end
    end
    in_tvalid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
